// File: rtl/csvft_pkg.sv
// csvft_pkg: constants, result kind codes and control/status structs
// for the CSV field tokenizer. No dependencies.
package csvft_pkg;

    // Default sizes
    localparam int HOLD_DEPTH_DEF       = 16;
    localparam int FIELD_COUNT_BITS_DEF = 16;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int FNUM_W   = 16;

    // Special characters
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    // Kind of result loaded into the output register
    localparam logic [1:0] KIND_FLUSH = 2'd0;  // held whitespace byte
    localparam logic [1:0] KIND_BYTE  = 2'd1;  // content byte
    localparam logic [1:0] KIND_CLOSE = 2'd2;  // field end from separator
    localparam logic [1:0] KIND_EOMC  = 2'd3;  // field end at end of message

    // Controller -> datapath
    typedef struct packed {
        logic       take;       // input item accepted this cycle
        logic       load;       // load a result into the output register
        logic [1:0] kind;       // which result
        logic       last;       // final result of this item
        logic       flush_adv;  // advance the hold buffer read index
    } ctl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic dec_emit;       // item emits a content byte
        logic dec_close;      // item is a separator that closes a field
        logic dec_eom;        // item ends the message
        logic held_nonempty;  // whitespace is held back
        logic out_free;       // output register can take a result
        logic flush_last;     // read index is at the last held byte
    } dp_stat_t;

endpackage

// File: rtl/csvft_ctrl.sv
// csvft_ctrl: sequencer that accepts one item and walks through its results.
// Depends on csvft_pkg.
module csvft_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  csvft_pkg::dp_stat_t  stat,
    output csvft_pkg::ctl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FLUSH = 3'd1;
    localparam logic [2:0] S_BYTE  = 3'd2;
    localparam logic [2:0] S_CLOSE = 3'd3;
    localparam logic [2:0] S_EOMC  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       emit_f_reg, emit_f_next;
    logic       close_f_reg, close_f_next;
    logic       eom_f_reg, eom_f_next;

    // State and item flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            emit_f_reg  <= 1'b0;
            close_f_reg <= 1'b0;
            eom_f_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            emit_f_reg  <= emit_f_next;
            close_f_reg <= close_f_next;
            eom_f_reg   <= eom_f_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        emit_f_next   = emit_f_reg;
        close_f_next  = close_f_reg;
        eom_f_next    = eom_f_reg;
        cmd.take      = 1'b0;
        cmd.load      = 1'b0;
        cmd.kind      = csvft_pkg::KIND_BYTE;
        cmd.last      = 1'b0;
        cmd.flush_adv = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid)
                begin
                    emit_f_next  = stat.dec_emit;
                    close_f_next = stat.dec_close;
                    eom_f_next   = stat.dec_eom;
                    if (stat.dec_emit && stat.held_nonempty)
                        state_next = S_FLUSH;
                    else if (stat.dec_emit)
                        state_next = S_BYTE;
                    else if (stat.dec_close)
                        state_next = S_CLOSE;
                    else if (stat.dec_eom)
                        state_next = S_EOMC;
                    else
                        state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                cmd.kind      = csvft_pkg::KIND_FLUSH;
                cmd.load      = stat.out_free;
                cmd.flush_adv = stat.out_free;
                if (stat.out_free && stat.flush_last)
                    state_next = S_BYTE;
            end
            S_BYTE:
            begin
                cmd.kind = csvft_pkg::KIND_BYTE;
                cmd.load = stat.out_free;
                cmd.last = !eom_f_reg;
                if (stat.out_free)
                    state_next = eom_f_reg ? S_EOMC : S_IDLE;
            end
            S_CLOSE:
            begin
                cmd.kind = csvft_pkg::KIND_CLOSE;
                cmd.load = stat.out_free;
                cmd.last = !eom_f_reg;
                if (stat.out_free)
                    state_next = eom_f_reg ? S_EOMC : S_IDLE;
            end
            S_EOMC:
            begin
                cmd.kind = csvft_pkg::KIND_EOMC;
                cmd.load = stat.out_free;
                cmd.last = 1'b1;
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A content byte and a separator close never come from the same item
    a_emit_close_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !(emit_f_reg && close_f_reg))
        else $error("emit and close flagged for one item");

    // Byte and flush states only serve items that emit content
    a_byte_needs_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BYTE || state_reg == S_FLUSH) |-> emit_f_reg)
        else $error("content state without content item");

    // The end-of-message close is always reached through an eom item
    a_eomc_needs_eom: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EOMC) |-> eom_f_reg)
        else $error("eom close without eom item");

endmodule

// File: rtl/csvft_dpath.sv
// csvft_dpath: parser state, byte decode, hold buffer memory, field counter
// and output register. Depends on csvft_pkg.
module csvft_dpath
#(
    parameter int HOLD_DEPTH       = csvft_pkg::HOLD_DEPTH_DEF,
    parameter int FIELD_COUNT_BITS = csvft_pkg::FIELD_COUNT_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [csvft_pkg::BYTE_W-1:0]    in_byte,
    input  logic                            end_of_message,
    input  csvft_pkg::ctl_cmd_t             cmd,
    output csvft_pkg::dp_stat_t             stat,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [csvft_pkg::BYTE_W-1:0]    out_byte,
    output logic                            byte_valid,
    output logic                            field_end,
    output logic [csvft_pkg::FNUM_W-1:0]    field_number,
    output logic                            ws_overflow,
    output logic                            last_of_run
);

    localparam int HC_W  = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    // Parser state
    logic                        quoting_reg, quoting_next;
    logic                        afs_reg, afs_next;
    logic                        pend_reg, pend_next;
    logic                        cs_reg, cs_next;
    logic [HC_W-1:0]             held_count_reg, held_count_next;
    logic [FIELD_COUNT_BITS-1:0] fcnt_reg, fcnt_next;
    logic                        ovf_reg, ovf_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    logic [csvft_pkg::BYTE_W-1:0] obyte_reg, obyte_next;
    logic                        obv_reg, obv_next;
    logic                        ofe_reg, ofe_next;
    logic [csvft_pkg::FNUM_W-1:0] ofn_reg, ofn_next;
    logic                        oovf_reg, oovf_next;
    logic                        olast_reg, olast_next;

    // Captured content byte of the current item
    logic [csvft_pkg::BYTE_W-1:0] cbyte_reg;

    // Hold buffer
    logic [csvft_pkg::BYTE_W-1:0] hold_mem [HOLD_DEPTH];
    logic [csvft_pkg::BYTE_W-1:0] rd_data_reg;

    // Decode
    logic is_quote, is_sep, is_ws, q_eff, addc;
    logic d_emit, d_close, d_hold, d_ovf;
    logic [31:0] fcnt_ext;

    // Classify the incoming byte and work out the item's effect
    always_comb
    begin
        is_quote = (in_byte == csvft_pkg::CH_QUOTE);
        is_sep   = (in_byte == csvft_pkg::CH_COMMA) || (in_byte == csvft_pkg::CH_NL);
        is_ws    = (in_byte == csvft_pkg::CH_SPACE) ||
                   ((in_byte >= csvft_pkg::CH_TAB) && (in_byte <= csvft_pkg::CH_CR));
        // a pending quote followed by anything but a quote ends quoting
        q_eff    = quoting_reg && !pend_reg;

        addc         = 1'b0;
        d_emit       = 1'b0;
        d_close      = 1'b0;
        d_hold       = 1'b0;
        d_ovf        = 1'b0;
        quoting_next = q_eff;
        afs_next     = afs_reg;
        pend_next    = 1'b0;
        cs_next      = cs_reg;

        if (pend_reg && is_quote)
        begin
            addc         = 1'b1;            // doubled quote inside quotes
            quoting_next = quoting_reg;     // still quoting
        end
        else if (is_quote)
        begin
            if (!q_eff && !afs_reg)
                addc = 1'b1;                // literal quote mid-field
            else if (q_eff)
            begin
                pend_next = 1'b1;           // may close, decided by next byte
                afs_next  = 1'b0;
            end
            else
            begin
                quoting_next = 1'b1;        // opening quote
                afs_next     = 1'b0;
            end
        end
        else if (is_sep && !q_eff)
            d_close = 1'b1;
        else
            addc = 1'b1;

        if (addc)
        begin
            afs_next = 1'b0;
            if (is_ws)
            begin
                if (cs_reg)
                begin
                    if (held_count_reg < HC_W'(HOLD_DEPTH))
                        d_hold = 1'b1;
                    else
                        d_ovf = 1'b1;
                end
            end
            else
            begin
                d_emit  = 1'b1;
                cs_next = 1'b1;
            end
        end

        if (d_close || end_of_message)
        begin
            quoting_next = 1'b0;
            afs_next     = 1'b1;
            pend_next    = 1'b0;
            cs_next      = 1'b0;
        end
    end

    // Status to the controller
    always_comb
    begin
        stat.dec_emit      = d_emit;
        stat.dec_close     = d_close;
        stat.dec_eom       = end_of_message;
        stat.held_nonempty = (held_count_reg != '0);
        stat.out_free      = !out_valid_reg || !out_stall;
        stat.flush_last    = ((HC_W'(idx_reg) + HC_W'(1)) == held_count_reg);
    end

    assign fcnt_ext = 32'(fcnt_reg);

    // State updates
    always_comb
    begin
        held_count_next = held_count_reg;
        fcnt_next       = fcnt_reg;
        ovf_next        = ovf_reg;
        idx_next        = idx_reg;

        if (cmd.take)
        begin
            if (d_emit)
                held_count_next = held_count_reg;       // cleared after flush
            else if (d_close || end_of_message)
                held_count_next = '0;
            else if (d_hold)
                held_count_next = held_count_reg + HC_W'(1);
            if (d_ovf)
                ovf_next = 1'b1;
        end

        // flush index walks the held bytes, then returns to entry zero
        if (cmd.flush_adv)
        begin
            if (stat.flush_last)
            begin
                idx_next        = '0;
                held_count_next = '0;
            end
            else
                idx_next = idx_reg + IDX_W'(1);
        end

        // close results advance the counter, end of message restarts it
        if (cmd.load && cmd.kind == csvft_pkg::KIND_CLOSE)
        begin
            if (fcnt_reg != '1)
                fcnt_next = fcnt_reg + FIELD_COUNT_BITS'(1);
            ovf_next = 1'b0;
        end
        else if (cmd.load && cmd.kind == csvft_pkg::KIND_EOMC)
        begin
            fcnt_next = '0;
            ovf_next  = 1'b0;
        end
    end

    // Output register next values
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        obyte_next     = obyte_reg;
        obv_next       = obv_reg;
        ofe_next       = ofe_reg;
        ofn_next       = ofn_reg;
        oovf_next      = oovf_reg;
        olast_next     = olast_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
            ofn_next       = fcnt_ext[csvft_pkg::FNUM_W-1:0];
            oovf_next      = ovf_reg;
            olast_next     = cmd.last;
            case (cmd.kind)
                csvft_pkg::KIND_FLUSH:
                begin
                    obyte_next = rd_data_reg;
                    obv_next   = 1'b1;
                    ofe_next   = 1'b0;
                end
                csvft_pkg::KIND_BYTE:
                begin
                    // content byte comes from the captured item
                    obyte_next = cbyte_reg;
                    obv_next   = 1'b1;
                    ofe_next   = 1'b0;
                end
                default:
                begin
                    obyte_next = '0;
                    obv_next   = 1'b0;
                    ofe_next   = 1'b1;
                end
            endcase
        end
    end

    // Capture the byte of the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.take)
            cbyte_reg <= in_byte;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quoting_reg    <= 1'b0;
            afs_reg        <= 1'b1;
            pend_reg       <= 1'b0;
            cs_reg         <= 1'b0;
            held_count_reg <= '0;
            fcnt_reg       <= '0;
            ovf_reg        <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                quoting_reg <= quoting_next;
                afs_reg     <= afs_next;
                pend_reg    <= pend_next;
                cs_reg      <= cs_next;
            end
            held_count_reg <= held_count_next;
            fcnt_reg       <= fcnt_next;
            ovf_reg        <= ovf_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Output payload registers
    always_ff @(posedge clk)
    begin
        obyte_reg <= obyte_next;
        obv_reg   <= obv_next;
        ofe_reg   <= ofe_next;
        ofn_reg   <= ofn_next;
        oovf_reg  <= oovf_next;
        olast_reg <= olast_next;
    end

    // Hold buffer: one write port, registered read at the next flush index
    always_ff @(posedge clk)
    begin
        if (cmd.take && d_hold && !end_of_message)
            hold_mem[held_count_reg[IDX_W-1:0]] <= in_byte;
        rd_data_reg <= hold_mem[idx_next];
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = obyte_reg;
    assign byte_valid   = obv_reg;
    assign field_end    = ofe_reg;
    assign field_number = ofn_reg;
    assign ws_overflow  = oovf_reg;
    assign last_of_run  = olast_reg;

    // Fill level never exceeds the buffer depth
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= HC_W'(HOLD_DEPTH))
        else $error("hold buffer fill level out of range");

    // A held byte is only flushed when there is one
    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && cmd.kind == csvft_pkg::KIND_FLUSH) |-> (held_count_reg != '0))
        else $error("flush with empty hold buffer");

    // End of message restarts the field count
    a_eom_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && cmd.kind == csvft_pkg::KIND_EOMC) |=> (fcnt_reg == '0))
        else $error("field counter not restarted at end of message");

    // A new result is loaded only when the output register can hold it
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a stalled result");

endmodule

// File: rtl/csv_field_tokenizer_top.sv
// csv_field_tokenizer_top: streaming CSV field tokenizer, top level.
// Depends on csvft_pkg, csvft_ctrl and csvft_dpath.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   input   | in_valid / in_stall | in_byte, end_of_message
//   output  | out_valid/out_stall | out_byte, byte_valid, field_end,
//           |                     | field_number, ws_overflow, last_of_run
//
// An item is accepted and then causes 0 to HOLD_DEPTH+2 results; the
// controller issues one result per cycle into a single output register
// while the output is not stalled, and held whitespace is read from the
// hold buffer memory one entry per cycle. in_stall is high while results
// of an item remain. rst_n is asynchronous, active low; no clearing pass
// follows it. A stalled output holds its result and pauses the sequencer.
module csv_field_tokenizer_top
#(
    parameter int HOLD_DEPTH       = csvft_pkg::HOLD_DEPTH_DEF,
    parameter int FIELD_COUNT_BITS = csvft_pkg::FIELD_COUNT_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [csvft_pkg::BYTE_W-1:0]    in_byte,
    input  logic                            end_of_message,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [csvft_pkg::BYTE_W-1:0]    out_byte,
    output logic                            byte_valid,
    output logic                            field_end,
    output logic [csvft_pkg::FNUM_W-1:0]    field_number,
    output logic                            ws_overflow,
    output logic                            last_of_run
);

    csvft_pkg::ctl_cmd_t cmd;
    csvft_pkg::dp_stat_t stat;

    csvft_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    csvft_dpath
    #(
        .HOLD_DEPTH       (HOLD_DEPTH),
        .FIELD_COUNT_BITS (FIELD_COUNT_BITS)
    )
    u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_byte        (in_byte),
        .end_of_message (end_of_message),
        .cmd            (cmd),
        .stat           (stat),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .field_end      (field_end),
        .field_number   (field_number),
        .ws_overflow    (ws_overflow),
        .last_of_run    (last_of_run)
    );

endmodule
